/* sv/psw_pkg.sv */
// shared types, constants and tables for the polyphonic square wave synth core
// no dependencies
package psw_pkg;

  localparam int VOICES_DEF   = 16;
  localparam int CHANNELS_DEF = 16;

  localparam int NUM_W  = 30;
  localparam int DEN_W  = 17;
  localparam int RATE_W = 17;

  localparam logic [RATE_W-1:0] RATE_RESET    = 17'd11025;
  localparam logic [RATE_W-1:0] RATE_FALLBACK = 17'd11025;
  localparam logic [6:0]        LEVEL_RESET   = 7'd127;
  localparam logic [6:0]        VOL_RESET     = 7'd100;
  localparam int                MIN_DIV       = 4;

  typedef enum logic [2:0] {
    MODE_NOTE_ON  = 3'd0,
    MODE_NOTE_OFF = 3'd1,
    MODE_CHAN_OFF = 3'd2,
    MODE_ALL_OFF  = 3'd3,
    MODE_SET_VOL  = 3'd4,
    MODE_RESET    = 3'd5,
    MODE_TICK     = 3'd6
  } mode_t;

  typedef enum logic [0:0] {
    CFG_SAMPLE_RATE  = 1'b0,
    CFG_OUTPUT_LEVEL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  level;
    logic [15:0] phase;
    logic [15:0] step;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  localparam logic [17:0] FREQ16 [128] = '{
    131, 139, 147, 156, 165, 175, 185, 196,
    208, 220, 233, 247, 262, 277, 294, 311,
    330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784,
    831, 880, 932, 988, 1047, 1109, 1175, 1245,
    1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
    2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136,
    3322, 3520, 3729, 3951, 4186, 4435, 4699, 4978,
    5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
    8372, 8870, 9397, 9956, 10548, 11175, 11840, 12544,
    13290, 14080, 14917, 15804, 16744, 17740, 18795, 19912,
    21096, 22351, 23680, 25088, 26580, 28160, 29834, 31609,
    33488, 35479, 37589, 39824, 42192, 44701, 47359, 50175,
    53159, 56320, 59669, 63217, 66976, 70959, 75178, 79649,
    84385, 89402, 94719, 100351, 106318, 112640, 119338, 126434,
    133952, 141918, 150356, 159297, 168769, 178805, 189437, 200702
  };

  // x / 127 for x up to 127*127
  function automatic logic [6:0] div127(input logic [13:0] x);
    logic [6:0] q0;
    logic [7:0] r;
    q0 = x[13:7];
    r  = {1'b0, x[6:0]} + {1'b0, q0};
    return (r >= 8'd127) ? q0 + 7'd1 : q0;
  endfunction

endpackage

/* sv/polyphonic_square_wave_synth_core.sv */
// top level: event sequencer around the voice ram, channel volume ram and divider
// depends on psw_pkg, psw_ram, psw_div
//
// One event is taken at a time. All off, reset, set channel volume and the unused code
// finish without leaving idle. Note off and channel off walk the voice ram, one voice read
// per cycle. A note on reads the channel volume, walks the voice ram to pick a voice,
// then runs the 30-bit phase step division, one bit per cycle. A tick walks the voice
// ram with read, scale and write-back of each phase, then divides the mix on the same
// divider and waits for the previous sample to be taken, if it has not been. The voice
// ram's single read port sets the walk length and the shared divider sets the rest.
module polyphonic_square_wave_synth_core #(
  parameter int VOICES   = psw_pkg::VOICES_DEF,
  parameter int CHANNELS = psw_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_channel,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_sample,
  output logic        out_clipped,
  output logic [4:0]  out_active_voices,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW  = $clog2(VOICES + 1);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MXW = $clog2(127 * VOICES + 1) + 1;
  localparam int SW  = MXW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_NVOL, S_NSCL, S_WALK, S_NDIV, S_NWAIT, S_NWR, S_TDIV, S_TWAIT, S_TOUT
  } state_t;

  state_t state_r;

  logic [psw_pkg::RATE_W-1:0] rate_r;
  logic [6:0]                 olev_r;

  logic [2:0]          mode_r;
  logic [3:0]          ch_r;
  logic [6:0]          note_r;
  logic [6:0]          lvl_r;
  logic [13:0]         prod_r;
  logic                vvr_r;

  logic [VOICES-1:0]   on_r;
  logic [CHANNELS-1:0] vv_r;

  logic [CW-1:0]       iss_r;
  logic                p1_v_r;
  logic [VW-1:0]       p1_idx_r;
  logic                p2_v_r;
  logic [VW-1:0]       p2_idx_r;
  psw_pkg::voice_t     p2_ent_r;
  logic [13:0]         p2_prod_r;

  logic                mfound_r;
  logic [VW-1:0]       midx_r;
  logic [6:0]          min_lvl_r;
  logic [VW-1:0]       min_idx_r;
  logic [VW-1:0]       sel_r;

  logic signed [MXW-1:0] mix_r;
  logic [CW-1:0]         act_r;
  logic                  neg_r;

  logic       out_valid_r;
  logic [7:0] out_sample_r;
  logic       out_clipped_r;
  logic [4:0] out_act_r;

  logic                      vm_we;
  logic [VW-1:0]             vm_waddr;
  psw_pkg::voice_t           vm_wdata;
  psw_pkg::voice_t           vm_rdata;
  logic [psw_pkg::VOICE_W-1:0] vm_rraw;

  logic            cv_we;
  logic [CHW-1:0]  cv_raddr;
  logic [6:0]      cv_rdata;

  psw_pkg::div_req_t div_req;
  psw_pkg::div_rsp_t div_rsp;

  logic          accept;
  logic [3:0]    ch_cl;
  logic          ch_ok;
  logic          issuing;
  logic          walk_done;
  logic [VW-1:0] free_idx;
  logic          any_free;
  logic [MXW-1:0] mag;
  logic [15:0]   step_val;
  logic signed [SW-1:0] qv;
  logic signed [SW-1:0] sv;
  logic [6:0]    amp;
  logic [6:0]    scaled;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ch_ok     = {1'b0, in_channel} < 5'(CHANNELS);
  assign ch_cl     = ch_ok ? in_channel : 4'(CHANNELS - 1);
  assign issuing   = iss_r < CW'(VOICES);
  assign walk_done = !issuing && !p1_v_r && !p2_v_r;
  assign cv_raddr  = ch_cl[CHW-1:0];
  assign cv_we     = accept && (in_mode == psw_pkg::MODE_SET_VOL) && ch_ok;
  assign vm_rdata  = psw_pkg::voice_t'(vm_rraw);
  assign amp       = psw_pkg::div127(p2_prod_r);
  assign scaled    = psw_pkg::div127(prod_r);
  assign mag       = neg_r ? MXW'(-mix_r) : MXW'(mix_r);
  assign qv        = signed'(SW'(div_rsp.quot[MXW-1:0]));
  assign sv        = neg_r ? (SW'(128) - qv) : (SW'(128) + qv);

  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!on_r[i]) begin
        free_idx = VW'(i);
      end
    end
    any_free = ~&on_r;
  end

  always_comb begin
    if (div_rsp.quot == '0) begin
      step_val = 16'd1;
    end else if (div_rsp.quot > psw_pkg::NUM_W'(16'hffff)) begin
      step_val = 16'hffff;
    end else begin
      step_val = div_rsp.quot[15:0];
    end
  end

  always_comb begin
    vm_we    = 1'b0;
    vm_waddr = p2_idx_r;
    vm_wdata = p2_ent_r;
    vm_wdata.phase = p2_ent_r.phase + p2_ent_r.step;
    if (state_r == S_WALK && p2_v_r) begin
      vm_we = 1'b1;
    end else if (state_r == S_NWR) begin
      vm_we            = 1'b1;
      vm_waddr         = sel_r;
      vm_wdata.channel = ch_r;
      vm_wdata.note    = note_r;
      vm_wdata.level   = lvl_r;
      vm_wdata.phase   = '0;
      vm_wdata.step    = step_val;
    end
  end

  always_comb begin
    div_req.start = (state_r == S_NDIV) || (state_r == S_TDIV);
    if (state_r == S_NDIV) begin
      div_req.num = {psw_pkg::FREQ16[note_r], 12'b0};
      div_req.den = (rate_r == '0) ? psw_pkg::RATE_FALLBACK : rate_r;
    end else begin
      div_req.num = psw_pkg::NUM_W'(mag);
      div_req.den = (act_r < CW'(psw_pkg::MIN_DIV)) ? psw_pkg::DEN_W'(psw_pkg::MIN_DIV)
                                                    : psw_pkg::DEN_W'(act_r);
    end
  end

  psw_ram #(.W(psw_pkg::VOICE_W), .D(VOICES), .AW(VW)) u_voice_ram (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (iss_r[VW-1:0]),
    .rdata (vm_rraw)
  );

  psw_ram #(.W(7), .D(CHANNELS), .AW(CHW)) u_vol_ram (
    .clk   (clk),
    .we    (cv_we),
    .waddr (in_channel[CHW-1:0]),
    .wdata (in_level),
    .raddr (cv_raddr),
    .rdata (cv_rdata)
  );

  psw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= psw_pkg::RATE_RESET;
      olev_r      <= psw_pkg::LEVEL_RESET;
      on_r        <= '0;
      vv_r        <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      iss_r       <= CW'(VOICES);
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (psw_pkg::cfg_idx_t'(cfg_index))
          psw_pkg::CFG_SAMPLE_RATE:  rate_r <= cfg_data;
          psw_pkg::CFG_OUTPUT_LEVEL: olev_r <= cfg_data[6:0];
        endcase
      end

      if (out_valid_r && out_ready && state_r != S_TOUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r    <= (in_mode == psw_pkg::MODE_NOTE_ON && in_level == '0)
                         ? psw_pkg::MODE_NOTE_OFF : in_mode;
            ch_r      <= (in_mode == psw_pkg::MODE_NOTE_ON) ? ch_cl : in_channel;
            note_r    <= in_note;
            lvl_r     <= in_level;
            vvr_r     <= vv_r[cv_raddr];
            iss_r     <= '0;
            mfound_r  <= 1'b0;
            min_lvl_r <= 7'd127;
            min_idx_r <= '0;
            mix_r     <= '0;
            act_r     <= '0;
            unique case (in_mode)
              psw_pkg::MODE_NOTE_ON: begin
                if (in_level == '0) begin
                  state_r <= S_WALK;
                end else begin
                  state_r <= S_NVOL;
                end
              end
              psw_pkg::MODE_NOTE_OFF, psw_pkg::MODE_CHAN_OFF, psw_pkg::MODE_TICK: begin
                state_r <= S_WALK;
              end
              psw_pkg::MODE_ALL_OFF: begin
                on_r <= '0;
              end
              psw_pkg::MODE_SET_VOL: begin
                if (ch_ok) begin
                  vv_r[in_channel[CHW-1:0]] <= 1'b1;
                end
              end
              psw_pkg::MODE_RESET: begin
                on_r <= '0;
                vv_r <= '0;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end else begin
            iss_r <= CW'(VOICES);
          end
        end

        S_NVOL: begin
          prod_r  <= lvl_r * (vvr_r ? cv_rdata : psw_pkg::VOL_RESET);
          iss_r   <= CW'(VOICES);
          state_r <= S_NSCL;
        end

        S_NSCL: begin
          lvl_r   <= (scaled == '0) ? 7'd1 : scaled;
          iss_r   <= '0;
          state_r <= S_WALK;
        end

        S_WALK: begin
          if (issuing) begin
            iss_r <= iss_r + CW'(1);
          end
          p1_v_r   <= issuing;
          p1_idx_r <= iss_r[VW-1:0];
          p2_v_r   <= p1_v_r && (mode_r == psw_pkg::MODE_TICK) && on_r[p1_idx_r];
          p2_idx_r  <= p1_idx_r;
          p2_ent_r  <= vm_rdata;
          p2_prod_r <= vm_rdata.level * olev_r;
          if (p1_v_r) begin
            priority case (mode_r)
              psw_pkg::MODE_NOTE_OFF: begin
                if (on_r[p1_idx_r] && vm_rdata.channel == ch_r && vm_rdata.note == note_r) begin
                  on_r[p1_idx_r] <= 1'b0;
                end
              end
              psw_pkg::MODE_CHAN_OFF: begin
                if (on_r[p1_idx_r] && vm_rdata.channel == ch_r) begin
                  on_r[p1_idx_r] <= 1'b0;
                end
              end
              psw_pkg::MODE_NOTE_ON: begin
                if (on_r[p1_idx_r] && vm_rdata.channel == ch_r && vm_rdata.note == note_r
                    && !mfound_r) begin
                  mfound_r <= 1'b1;
                  midx_r   <= p1_idx_r;
                end
                if (vm_rdata.level < min_lvl_r) begin
                  min_lvl_r <= vm_rdata.level;
                  min_idx_r <= p1_idx_r;
                end
              end
              default: begin
                mfound_r <= mfound_r;
              end
            endcase
          end
          if (p2_v_r) begin
            mix_r <= p2_ent_r.phase[15] ? mix_r + signed'(MXW'(amp))
                                        : mix_r - signed'(MXW'(amp));
            act_r <= act_r + CW'(1);
          end
          if (walk_done) begin
            if (mode_r == psw_pkg::MODE_NOTE_ON) begin
              state_r <= S_NDIV;
            end else if (mode_r == psw_pkg::MODE_TICK) begin
              state_r <= S_TDIV;
              neg_r   <= mix_r < 0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_NDIV: begin
          sel_r   <= mfound_r ? midx_r : (any_free ? free_idx : min_idx_r);
          state_r <= S_NWAIT;
        end

        S_NWAIT: begin
          if (div_rsp.done) begin
            state_r <= S_NWR;
          end
        end

        S_NWR: begin
          on_r[sel_r] <= 1'b1;
          state_r     <= S_IDLE;
        end

        S_TDIV: begin
          state_r <= S_TWAIT;
        end

        S_TWAIT: begin
          if (div_rsp.done) begin
            state_r <= S_TOUT;
          end
        end

        S_TOUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_act_r   <= 5'(act_r);
            if (sv < 0) begin
              out_sample_r  <= 8'd0;
              out_clipped_r <= 1'b1;
            end else if (sv > SW'(255)) begin
              out_sample_r  <= 8'd255;
              out_clipped_r <= 1'b1;
            end else begin
              out_sample_r  <= sv[7:0];
              out_clipped_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = out_sample_r;
  assign out_clipped       = out_clipped_r;
  assign out_active_voices = out_act_r;

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_NWAIT || state_r == S_TWAIT))
    else $error("divider finished with nobody waiting");

  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_TOUT))
    else $error("sample beat raised outside tick completion");

  a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= CW'(VOICES))
    else $error("active voice count overflow");

  a_ram_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vm_we |-> state_r != S_IDLE)
    else $error("voice ram written while idle");
`endif

endmodule

/* sv/psw_ram.sv */
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
module psw_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/psw_div.sv */
// restoring divider, one quotient bit per cycle
// depends on psw_pkg
module psw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  psw_pkg::div_req_t  req,
  output psw_pkg::div_rsp_t  rsp
);

  localparam int NW = psw_pkg::NUM_W;
  localparam int DW = psw_pkg::DEN_W;
  localparam int CNW = $clog2(NW);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [NW-1:0]  q_r;
  logic [DW-1:0]  rem_r;
  logic [DW-1:0]  den_r;

  logic [DW:0]    trial;
  logic           ge;
  logic [DW:0]    diff;

  always_comb begin
    trial = {rem_r, q_r[NW-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(NW - 1);
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= {q_r[NW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

/* sim/polyphonic_square_wave_synth_core_test.sv */
// self-checking testbench for the polyphonic square wave synth core
// depends on psw_pkg and polyphonic_square_wave_synth_core; event beats are predicted
// in a behavioral voice model and every sample beat is compared against it
module polyphonic_square_wave_synth_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 16;
  localparam int NC = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] sample;
    logic       clipped;
    logic [4:0] active;
  } mix_t;

  typedef struct {
    logic [2:0] mode;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] level;
    logic       known;
    mix_t       mix;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [3:0]  in_channel = '0;
  logic [6:0]  in_note = '0;
  logic [6:0]  in_level = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_sample;
  logic        out_clipped;
  logic [4:0]  out_active_voices;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  polyphonic_square_wave_synth_core i_dut (.*);

  always #5 clk = ~clk;

  logic [16:0] rate_q;
  logic [6:0]  olevel_q;
  logic        von [NV];
  logic [3:0]  vch [NV];
  logic [6:0]  vnote [NV];
  logic [6:0]  vlev [NV];
  logic [15:0] vphase [NV];
  logic [15:0] vstep [NV];
  logic [6:0]  chvol [NC];

  mix_t        expected_mix[$];
  logic        mix_known[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic clear_voices();
    for (int i = 0; i < NV; i++) begin
      von[i] = 1'b0; vch[i] = '0; vnote[i] = '0; vlev[i] = '0; vphase[i] = '0;
      vstep[i] = '0;
    end
    for (int i = 0; i < NC; i++) chvol[i] = psw_pkg::VOL_RESET;
  endtask

  task automatic release_voices(input logic [3:0] ch, input logic [6:0] nt);
    for (int i = 0; i < NV; i++)
      if (von[i] && vch[i] == ch && vnote[i] == nt) von[i] = 1'b0;
  endtask

  task automatic predict_event(input logic [2:0] mode, input logic [3:0] ch,
                               input logic [6:0] nt, input logic [6:0] lv,
                               input logic known, input mix_t given);
    int   scaled, v, amp, mix, active, s;
    longint st, rate;
    mix_t r;
    case (mode)
      psw_pkg::MODE_NOTE_ON: begin
        if (lv == 0) begin
          release_voices(ch, nt);
        end else begin
          scaled = (int'(lv) * int'(chvol[ch])) / 127;
          if (scaled == 0) scaled = 1;
          v = -1;
          for (int i = 0; i < NV; i++)
            if (v < 0 && von[i] && vch[i] == ch && vnote[i] == nt) v = i;
          for (int i = 0; i < NV; i++)
            if (v < 0 && !von[i]) v = i;
          if (v < 0) begin
            v = 0;
            for (int i = 1; i < NV; i++) if (vlev[i] < vlev[v]) v = i;
          end
          rate = (rate_q == 0) ? 11025 : longint'(rate_q);
          st = (longint'(psw_pkg::FREQ16[nt]) * 4096) / rate;
          if (st == 0) st = 1;
          if (st > 65535) st = 65535;
          von[v] = 1'b1; vch[v] = ch; vnote[v] = nt; vlev[v] = scaled[6:0];
          vphase[v] = '0; vstep[v] = st[15:0];
        end
      end
      psw_pkg::MODE_NOTE_OFF: release_voices(ch, nt);
      psw_pkg::MODE_CHAN_OFF:
        for (int i = 0; i < NV; i++) if (von[i] && vch[i] == ch) von[i] = 1'b0;
      psw_pkg::MODE_ALL_OFF: for (int i = 0; i < NV; i++) von[i] = 1'b0;
      psw_pkg::MODE_SET_VOL: chvol[ch] = lv;
      psw_pkg::MODE_RESET: clear_voices();
      psw_pkg::MODE_TICK: begin
        mix = 0; active = 0;
        for (int i = 0; i < NV; i++) begin
          if (von[i]) begin
            amp = (int'(vlev[i]) * int'(olevel_q)) / 127;
            mix += vphase[i][15] ? amp : -amp;
            vphase[i] = vphase[i] + vstep[i];
            active++;
          end
        end
        if (active > 0) mix = mix / (active < 4 ? 4 : active);
        s = 128 + mix;
        r.clipped = (s < 0 || s > 255);
        r.sample = s < 0 ? 8'd0 : (s > 255 ? 8'd255 : s[7:0]);
        r.active = active[4:0];
        if (known && r != given) report("table row", int'(given), int'(r));
        expected_mix.push_back(known ? given : r);
        mix_known.push_back(known);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyphonic_square_wave_synth_core_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        report("unexpected sample beat", out_sample, -1);
      end else begin
        mix_t e;
        e = expected_mix.pop_front();
        void'(mix_known.pop_front());
        if (out_sample !== e.sample) report("sample", out_sample, e.sample);
        if (out_clipped !== e.clipped) report("clipped", out_clipped, e.clipped);
        if (out_active_voices !== e.active)
          report("active_voices", out_active_voices, e.active);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // in_valid stays high between back to back beats and is dropped only on idle or drain
  task automatic send_event(input logic [2:0] mode, input logic [3:0] ch,
                            input logic [6:0] nt, input logic [6:0] lv,
                            input logic known, input mix_t given);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode; in_channel <= ch; in_note <= nt; in_level <= lv;
    do @(posedge clk); while (!in_ready);
    predict_event(mode, ch, nt, lv, known, given);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input psw_pkg::cfg_idx_t idx, input logic [16:0] data);
    drain();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == psw_pkg::CFG_SAMPLE_RATE) rate_q = data; else olevel_q = data[6:0];
  endtask

  task automatic random_events(input int n);
    logic [2:0] m;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) m = psw_pkg::MODE_NOTE_ON;
      else if (r < 70) m = psw_pkg::MODE_TICK;
      else if (r < 80) m = psw_pkg::MODE_NOTE_OFF;
      else m = 3'($urandom_range(7));
      if (k == n / 2) drain();
      send_event(m, 4'($urandom_range(15)),
                 7'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(40, 72)),
                 7'($urandom_range(127)), 1'b0, '0);
    end
  endtask

  row_t dir [$];

  function automatic row_t mk(input logic [2:0] m, input int c, input int n, input int l,
                              input logic k = 0, input mix_t x = '0);
    row_t r;
    r.mode = m; r.channel = 4'(c); r.note = 7'(n); r.level = 7'(l); r.known = k;
    r.mix = x;
    return r;
  endfunction

  initial begin
    rate_q = psw_pkg::RATE_RESET;
    olevel_q = psw_pkg::LEVEL_RESET;
    clear_voices();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0, 1, '{8'd128, 1'b0, 5'd0}));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 0, 0, 127));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 15, 127, 1));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_SET_VOL, 3, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 3, 60, 127));
    dir.push_back(mk(psw_pkg::MODE_SET_VOL, 4, 0, 127));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 4, 60, 127));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 4, 60, 90));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_NOTE_OFF, 4, 60, 0));
    dir.push_back(mk(psw_pkg::MODE_CHAN_OFF, 15, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0));
    for (int i = 0; i < 18; i++)
      dir.push_back(mk(psw_pkg::MODE_NOTE_ON, i % 16, 100 + i, 10 + i));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_ALL_OFF, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0, 1, '{8'd128, 1'b0, 5'd0}));
    dir.push_back(mk(3'd7, 15, 127, 127));
    dir.push_back(mk(psw_pkg::MODE_NOTE_ON, 9, 5, 50));
    dir.push_back(mk(psw_pkg::MODE_RESET, 0, 0, 0));
    dir.push_back(mk(psw_pkg::MODE_TICK, 0, 0, 0, 1, '{8'd128, 1'b0, 5'd0}));
    foreach (dir[i])
      send_event(dir[i].mode, dir[i].channel, dir[i].note, dir[i].level,
                 dir[i].known, dir[i].mix);

    write_reg(psw_pkg::CFG_SAMPLE_RATE, 17'd1000);
    write_reg(psw_pkg::CFG_OUTPUT_LEVEL, 17'd0);
    send_idle = 7; recv_idle = 76;
    random_events(250);
    write_reg(psw_pkg::CFG_SAMPLE_RATE, 17'd96000);
    write_reg(psw_pkg::CFG_OUTPUT_LEVEL, 17'd127);
    send_idle = 76; recv_idle = 7;
    random_events(250);
    write_reg(psw_pkg::CFG_SAMPLE_RATE, 17'd0);
    write_reg(psw_pkg::CFG_OUTPUT_LEVEL, 17'd64);
    send_idle = 0; recv_idle = 0;
    random_events(250);
    write_reg(psw_pkg::CFG_SAMPLE_RATE, 17'h1ffff);
    write_reg(psw_pkg::CFG_OUTPUT_LEVEL, 17'd127);
    random_events(250);
    drain();

    if (errors == 0) begin
      $display("polyphonic_square_wave_synth_core_test: PASS");
    end else begin
      $display("polyphonic_square_wave_synth_core_test: FAIL");
    end
    $finish;
  end
endmodule
